>>> hdl/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// shared types, codes and helpers for the circular child ring manager
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = 10;
  localparam int ADDR_W     = $clog2(NODE_COUNT);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam idx_t  NIL        = '0;
  localparam addr_t CLEAR_LAST = addr_t'(NODE_COUNT - 1);

  localparam logic [1:0] OP_PREPEND = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_UNLINK  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    idx_t       parent_node;
    idx_t       child_node;
  } in_word_t;

  typedef struct packed {
    logic status;
    idx_t head_child;
    idx_t tail_child;
    idx_t child_next;
    idx_t child_prev;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load_in;
    logic rd_chain;
    logic cap1;
    logic cap2;
    logic cap3;
    logic write1;
    logic write2;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

  function automatic addr_t to_addr(idx_t idx);
    logic [ADDR_W+IDX_W-1:0] wide;
    wide = {{ADDR_W{1'b0}}, idx};
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic in_range(idx_t idx);
    return 32'(idx) < 32'(NODE_COUNT);
  endfunction

endpackage

>>> hdl/ccr_ram.sv
// ----------------------------------------------------------------------------
// ccr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ccr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ccr_ctrl.sv
// ----------------------------------------------------------------------------
// ccr_ctrl
// sequencer: clearing pass, three read steps, two write steps
// ----------------------------------------------------------------------------
module ccr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ccr_pkg::stat_t stat,
  output ccr_pkg::cmd_t  cmd
);
  import ccr_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_RD3   = 3'd4;
  localparam logic [2:0] S_WR1   = 3'd5;
  localparam logic [2:0] S_WR2   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_RD1;
        end
      end
      S_RD1: begin
        cmd.cap1     = 1'b1;
        cmd.rd_chain = 1'b1;
        state_next   = S_RD2;
      end
      S_RD2: begin
        cmd.cap2     = 1'b1;
        cmd.rd_chain = 1'b1;
        state_next   = S_RD3;
      end
      S_RD3: begin
        cmd.cap3   = 1'b1;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.write1 = 1'b1;
        state_next = S_WR2;
      end
      S_WR2: begin
        // hold here while the previous word still sits in the output register
        if (stat.out_free) begin
          cmd.write2   = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/ccr_datapath.sv
// ----------------------------------------------------------------------------
// ccr_datapath
// link stores, operand registers, link update and result register
// ----------------------------------------------------------------------------
module ccr_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ccr_pkg::cmd_t       cmd,
  output ccr_pkg::stat_t      stat,
  input  ccr_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccr_pkg::out_word_t  out_data
);
  import ccr_pkg::*;

  addr_t clr_cnt;

  logic [1:0] op_q;
  idx_t p_q, c_q;
  idx_t par_c, hd_p, nxt_c, prv_c;
  idx_t last_q, hd_u, tail_u;

  logic  par_we, hd_we, nxt_we, prv_we;
  addr_t par_waddr, hd_waddr, nxt_waddr, prv_waddr;
  idx_t  par_wdata, hd_wdata, nxt_wdata, prv_wdata;
  addr_t par_raddr, hd_raddr, nxt_raddr, prv_raddr;
  idx_t  par_rdata, hd_rdata, nxt_rdata, prv_rdata;

  logic is_add, is_del, p_ok, c_ok, c_in, p_in;
  logic add_ok, del_ok, first_empty, single;
  out_word_t res;

  ccr_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_par (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );
  ccr_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_hd (
    .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(hd_raddr), .rdata(hd_rdata)
  );
  ccr_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata)
  );
  ccr_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_prv (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(prv_raddr), .rdata(prv_rdata)
  );

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clear_last = (clr_cnt == CLEAR_LAST);
  assign stat.out_free   = !out_valid || out_ready;

  // operand and read-back registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q <= in_data.op;
      p_q  <= in_data.parent_node;
      c_q  <= in_data.child_node;
    end
    if (cmd.cap1) begin
      par_c <= par_rdata;
      hd_p  <= hd_rdata;
      nxt_c <= nxt_rdata;
      prv_c <= prv_rdata;
    end
    if (cmd.cap2) begin
      last_q <= prv_rdata;
      hd_u   <= hd_rdata;
    end
    if (cmd.cap3) begin
      tail_u <= prv_rdata;
    end
  end

  // first reads come from the input word, later ones chain off read data
  assign par_raddr = to_addr(in_data.child_node);
  assign nxt_raddr = to_addr(in_data.child_node);
  assign hd_raddr  = cmd.rd_chain ? to_addr(par_rdata) : to_addr(in_data.parent_node);
  assign prv_raddr = cmd.rd_chain ? to_addr(hd_rdata) : to_addr(in_data.child_node);

  assign is_add      = (op_q == OP_PREPEND) || (op_q == OP_APPEND);
  assign is_del      = (op_q == OP_UNLINK);
  assign c_in        = in_range(c_q);
  assign p_in        = in_range(p_q);
  assign c_ok        = (c_q != NIL) && c_in;
  assign p_ok        = (p_q != NIL) && p_in;
  assign add_ok      = is_add && c_ok && p_ok && (c_q != p_q) && (par_c == NIL);
  assign del_ok      = is_del && c_ok && (par_c != NIL);
  assign first_empty = (hd_p == NIL);
  assign single      = (nxt_c == c_q);

  // link updates
  always_comb begin
    par_we    = 1'b0;
    hd_we     = 1'b0;
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    par_waddr = to_addr(c_q);
    hd_waddr  = to_addr(p_q);
    nxt_waddr = to_addr(c_q);
    prv_waddr = to_addr(c_q);
    par_wdata = NIL;
    hd_wdata  = NIL;
    nxt_wdata = NIL;
    prv_wdata = NIL;
    if (cmd.clear) begin
      par_we    = 1'b1;
      hd_we     = 1'b1;
      nxt_we    = 1'b1;
      prv_we    = 1'b1;
      par_waddr = clr_cnt;
      hd_waddr  = clr_cnt;
      nxt_waddr = clr_cnt;
      prv_waddr = clr_cnt;
    end else if (cmd.write1) begin
      if (add_ok) begin
        par_we    = 1'b1;
        par_wdata = p_q;
        if (first_empty) begin
          hd_we     = 1'b1;
          hd_wdata  = c_q;
          nxt_we    = 1'b1;
          nxt_wdata = c_q;
          prv_we    = 1'b1;
          prv_wdata = c_q;
        end else begin
          nxt_we    = 1'b1;
          nxt_waddr = to_addr(last_q);
          nxt_wdata = c_q;
          prv_we    = 1'b1;
          prv_wdata = last_q;
          if (op_q == OP_PREPEND) begin
            hd_we    = 1'b1;
            hd_wdata = c_q;
          end
        end
      end else if (del_ok) begin
        par_we   = 1'b1;
        nxt_we   = 1'b1;
        prv_we   = 1'b1;
        hd_waddr = to_addr(par_c);
        if (single) begin
          hd_we = 1'b1;
        end else if (hd_u == c_q) begin
          hd_we    = 1'b1;
          hd_wdata = nxt_c;
        end
      end
    end else if (cmd.write2) begin
      if (add_ok && !first_empty) begin
        nxt_we    = 1'b1;
        nxt_wdata = hd_p;
        prv_we    = 1'b1;
        prv_waddr = to_addr(hd_p);
        prv_wdata = c_q;
      end else if (del_ok && !single) begin
        nxt_we    = 1'b1;
        nxt_waddr = to_addr(prv_c);
        nxt_wdata = nxt_c;
        prv_we    = 1'b1;
        prv_waddr = to_addr(nxt_c);
        prv_wdata = prv_c;
      end
    end
  end

  // result word
  always_comb begin
    res.status     = !(add_ok || del_ok);
    res.child_next = c_in ? nxt_c : NIL;
    res.child_prev = c_in ? prv_c : NIL;
    res.head_child = NIL;
    res.tail_child = NIL;
    if (add_ok) begin
      if (first_empty) begin
        res.head_child = c_q;
        res.tail_child = c_q;
        res.child_next = c_q;
        res.child_prev = c_q;
      end else begin
        res.head_child = (op_q == OP_PREPEND) ? c_q : hd_p;
        res.tail_child = (op_q == OP_PREPEND) ? last_q : c_q;
        res.child_next = hd_p;
        res.child_prev = last_q;
      end
    end else if (del_ok) begin
      res.child_next = NIL;
      res.child_prev = NIL;
      if (!single) begin
        res.head_child = (hd_u == c_q) ? nxt_c : hd_u;
        res.tail_child = (tail_u == c_q) ? prv_c : tail_u;
      end
    end else if (!is_del) begin
      res.head_child = p_in ? hd_p : NIL;
      res.tail_child = (p_in && (hd_p != NIL)) ? last_q : NIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

endmodule

>>> hdl/circular_child_ring_manager.sv
// ----------------------------------------------------------------------------
// circular_child_ring_manager
// node table with one circular doubly-linked ring of children per parent
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_data): one request word per item, op is
//   prepend, append or unlink, with parent and child node indexes
//   out channel (out_valid/out_ready/out_data): one result word per request,
//   carrying status, the affected ring's head and tail, and the child's links
//   sequence: an accepted request runs read steps RD1-RD3, then write steps
//   WR1 and WR2, loading its result in WR2 once the output register is free
//   one request at a time (in_ready only in idle), as set by the single write
//   port of each store (up to two writes per store) behind three chained reads
//   reset: rst is synchronous; afterwards a clearing pass zeroes all four
//   stores, one entry a cycle, all NODE_COUNT (1024) entries, with in_ready low
//   stall: a held result sits in the output register; a new request is still
//   accepted and worked on, then waits in its final step until out_ready
//   frees the register
// ----------------------------------------------------------------------------
module circular_child_ring_manager (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ccr_pkg::out_word_t out_data
);
  import ccr_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: clear sweep, read chain, write pair, result load
  ccr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // link stores, operand registers and result register
  ccr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hdl/ccr_checker.sv
// ----------------------------------------------------------------------------
// ccr_checker
// port-level checks for the circular child ring manager
// ----------------------------------------------------------------------------
module ccr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ccr_pkg::out_word_t out_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // clearing pass keeps input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open during clearing pass");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in flight");

  // no result appears the cycle after a request is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind circular_child_ring_manager ccr_checker u_ccr_checker (.*);

>>> bench/circular_child_ring_manager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_child_ring_manager_tb
// checks the child ring manager against a predictor of its link tables
// ----------------------------------------------------------------------------
// a short directed run builds and tears down one ring at the index extremes
// and hits every reject path, then random traffic over small node pools keeps
// many rings alive so that adds, unlinks and rejects all reach deep states;
// every result word is compared field by field with the predicted one
// ----------------------------------------------------------------------------
module circular_child_ring_manager_tb;
  import ccr_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          MAX_REPORTS = 10;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  // clock, reset and both channels; the bench-driven ones are known from time zero
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // idle rates in percent for the sender and the receiver
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 47;

  // predicted link tables, mirror of the block's four stores
  idx_t ring_parent [NODE_COUNT];
  idx_t ring_next   [NODE_COUNT];
  idx_t ring_prev   [NODE_COUNT];
  idx_t ring_first  [NODE_COUNT];

  // result words still owed by the block, oldest first
  out_word_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned checked_words  = 0;
  int unsigned cycle_count    = 0;

  circular_child_ring_manager dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // watchdog: the slowest legal run is far below this
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_child_ring_manager_tb NOT OK");
      $finish;
    end
  end

  // receiver side: stall at random, changes land on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic in_table(idx_t idx);
    return 32'(idx) < 32'(NODE_COUNT);
  endfunction

  // apply one request word to the predicted tables and build its result word
  function automatic out_word_t apply_request(in_word_t req);
    idx_t      p, c, report, first, last, pv, nx, head;
    logic      done, c_ok;
    out_word_t res;
    p      = req.parent_node;
    c      = req.child_node;
    report = p;
    done   = 1'b0;
    c_ok   = (c != NIL) && in_table(c);
    case (req.op)
      OP_PREPEND, OP_APPEND: begin
        // guard: no nil, no self link, child must be free
        if (c_ok && p != NIL && in_table(p) && c != p && ring_parent[c] == NIL) begin
          first          = ring_first[p];
          ring_parent[c] = p;
          if (first == NIL) begin
            // first child forms a ring of one
            ring_first[p] = c;
            ring_next[c]  = c;
            ring_prev[c]  = c;
          end else begin
            // splice in between the tail and the head
            last             = ring_prev[first];
            ring_next[last]  = c;
            ring_prev[c]     = last;
            ring_next[c]     = first;
            ring_prev[first] = c;
            if (req.op == OP_PREPEND) begin
              ring_first[p] = c;
            end
          end
          done = 1'b1;
        end
      end
      OP_UNLINK: begin
        if (c_ok && ring_parent[c] != NIL) begin
          // the ring the child leaves is the one reported
          report = ring_parent[c];
          if (ring_next[c] == c) begin
            ring_first[report] = NIL;
          end else begin
            pv            = ring_prev[c];
            nx            = ring_next[c];
            ring_next[pv] = nx;
            ring_prev[nx] = pv;
            if (ring_first[report] == c) begin
              ring_first[report] = nx;
            end
          end
          ring_parent[c] = NIL;
          ring_next[c]   = NIL;
          ring_prev[c]   = NIL;
          done           = 1'b1;
        end else begin
          report = NIL;
        end
      end
      default: begin
        // unused op code leaves everything alone
      end
    endcase
    head           = in_table(report) ? ring_first[report] : NIL;
    res.status     = ~done;
    res.head_child = head;
    res.tail_child = (head != NIL) ? ring_prev[head] : NIL;
    res.child_next = in_table(c) ? ring_next[c] : NIL;
    res.child_prev = in_table(c) ? ring_prev[c] : NIL;
    return res;
  endfunction

  function automatic in_word_t request(logic [1:0] op, int unsigned p, int unsigned c);
    in_word_t w;
    w.op          = op;
    w.parent_node = idx_t'(p);
    w.child_node  = idx_t'(c);
    return w;
  endfunction

  function automatic void check_field(string field_name, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("mismatch on result word %0d: %s expected %0d got %0d",
                 checked_words, field_name, want, got);
      end
    end
  endfunction

  // result checker: sample the out channel at the rising edge
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        // a word nobody asked for
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result word %0d: %p", checked_words, out_data);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("status",     want.status,     out_data.status);
        check_field("head_child", want.head_child, out_data.head_child);
        check_field("tail_child", want.tail_child, out_data.tail_child);
        check_field("child_next", want.child_next, out_data.child_next);
        check_field("child_prev", want.child_prev, out_data.child_prev);
      end
      checked_words++;
    end
  end

  // send one request word; random idle cycles go before it on the falling edge,
  // and the prediction is made at the edge where the word is taken
  task automatic send_request(input in_word_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_results.push_back(apply_request(req));
  endtask

  // hold the sender off until every owed word has come back
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // node pick: mostly the low end of the table, sometimes the mirrored top end
  function automatic int unsigned pick_node(int unsigned span);
    if ($urandom_range(99) < 85) begin
      return $urandom_range(span, 1);
    end
    return NODE_COUNT - 1 - $urandom_range(span - 1, 0);
  endfunction

  // one ring under the top parent built and torn down, plus every reject
  task automatic test_directed_rings();
    send_request(request(OP_PREPEND, 1023, 1));     // empty ring gets its first child
    send_request(request(OP_APPEND,  1023, 1022));
    send_request(request(OP_PREPEND, 1023, 2));     // new head
    send_request(request(OP_APPEND,  1023, 3));     // new tail
    send_request(request(OP_PREPEND, 0,    5));     // nil parent
    send_request(request(OP_APPEND,  1023, 0));     // nil child
    send_request(request(OP_PREPEND, 7,    7));     // child is its own parent
    send_request(request(OP_APPEND,  6,    1));     // child already linked
    send_request(request(OP_APPEND,  0,    0));
    send_request(request(OP_UNUSED,  1023, 1));
    send_request(request(OP_UNUSED,  0,    0));
    send_request(request(OP_UNUSED,  682,  341));
    send_request(request(OP_PREPEND, 1,    1023));  // a parent can be a child too
    send_request(request(OP_UNLINK,  1023, 2));     // head leaves
    send_request(request(OP_UNLINK,  0,    3));     // tail leaves
    send_request(request(OP_UNLINK,  512,  1));     // head of two leaves
    send_request(request(OP_UNLINK,  1023, 1022));  // last child, ring goes empty
    send_request(request(OP_UNLINK,  341,  1023));
    send_request(request(OP_UNLINK,  682,  1023));  // unlink of an unlinked node
    send_request(request(OP_UNLINK,  1023, 0));     // nil child
    send_request(request(OP_UNLINK,  0,    512));   // never linked
  endtask

  // random traffic over small pools so rings grow, shrink and nest
  task automatic test_random_rings(input int unsigned words,
                                   input int unsigned parent_span,
                                   input int unsigned child_span);
    int unsigned roll;
    in_word_t    w;
    repeat (words) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        // noise: any op, any index
        w = in_word_t'($urandom);
      end else if (roll < 10) begin
        w = request(OP_UNUSED, pick_node(parent_span), pick_node(child_span));
      end else if (roll < 55) begin
        w = request($urandom_range(1) ? OP_APPEND : OP_PREPEND,
                    pick_node(parent_span), pick_node(child_span));
      end else begin
        // the parent field is ignored on unlink, so fill it with junk
        w = request(OP_UNLINK, $urandom_range(NODE_COUNT - 1), pick_node(child_span));
      end
      send_request(w);
    end
  endtask

  initial begin
    foreach (ring_parent[i]) begin
      ring_parent[i] = NIL;
      ring_next[i]   = NIL;
      ring_prev[i]   = NIL;
      ring_first[i]  = NIL;
    end

    // single reset; the block clears its stores afterwards with in_ready low
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_rings();
    wait_until_drained();

    // sender rarely idle, receiver often stalled
    send_idle_pct = 13;
    recv_idle_pct = 47;
    test_random_rings(340, 3, 20);
    wait_until_drained();

    // the other way round
    send_idle_pct = 47;
    recv_idle_pct = 13;
    test_random_rings(340, 6, 32);
    wait_until_drained();

    // back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_rings(320, 2, 12);
    wait_until_drained();

    // let any stray word show up before the verdict
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("circular_child_ring_manager_tb OK");
    end else begin
      $display("circular_child_ring_manager_tb NOT OK");
    end
    $finish;
  end

endmodule
